FILE: rtl/core/tvp_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner package
// Shared constants, state codes and saturation helpers for the planner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvp_pkg;

  localparam int DEF_MAX_ITERATIONS = 1024;
  localparam int DEF_FRAC_BITS      = 16;

  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;
  localparam int DVD_W   = 64;
  localparam int DVS_W   = 33;
  localparam int MOP_W   = 34;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATIO = 2'd3;

  localparam logic [CFG_W-1:0] RST_MAX_ACCEL     = 31'd65536;
  localparam logic [CFG_W-1:0] RST_MAX_SPEED     = 31'd65536;
  localparam logic [CFG_W-1:0] RST_TIME_STEP     = 31'd655;
  localparam logic [CFG_W-1:0] RST_INITIAL_RATIO = 31'd65536;

  localparam logic [CFG_W-1:0] MAX31   = 31'h7FFF_FFFF;
  localparam logic [31:0]      S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]      S32_MIN = 32'h8000_0000;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_PASS  = 18'h00002,
    S_CHECK = 18'h00004,
    S_T1    = 18'h00008,
    S_T3    = 18'h00010,
    S_M1    = 18'h00020,
    S_M2    = 18'h00040,
    S_WD    = 18'h00080,
    S_A1L   = 18'h00100,
    S_A1    = 18'h00200,
    S_A3L   = 18'h00400,
    S_A3    = 18'h00800,
    S_UPD   = 18'h01000,
    S_END   = 18'h02000,
    S_KM    = 18'h04000,
    S_KL    = 18'h08000,
    S_KD    = 18'h10000,
    S_DONE  = 18'h20000
  } state_t;

  // Signed 32 bit saturation of a value given as sign and magnitude.
  function automatic logic [31:0] sat_sm(input logic neg, input logic [DVD_W-1:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (mag > DVD_W'(S32_MAX)) ? S32_MAX : mag[31:0];
    end else begin
      res = (mag > DVD_W'(S32_MIN)) ? S32_MIN : (32'd0 - mag[31:0]);
    end
    return res;
  endfunction

  // Rate reported when the segment time is zero.
  function automatic logic [31:0] zero_time_rate(input logic signed [32:0] diff);
    logic [31:0] res;
    if (diff > 33'sd0) begin
      res = S32_MAX;
    end else if (diff < 33'sd0) begin
      res = S32_MIN;
    end else begin
      res = 32'd0;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/trapezoid_velocity_planner.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner
// Plans an accelerate, cruise, decelerate speed profile for one move request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the plan is delivered as a single out_valid beat that the receiver
// must take in that cycle. The work runs through one restoring divider (one
// quotient bit a cycle) and one registered multiplier under a sequencer. A
// search step costs five divisions, or one fewer for each segment time of
// zero; a request runs two search passes of up to MAX_ITERATIONS steps each,
// with one ratio division between them when the first pass ran and its cruise
// speed differs from the start and end speeds, so the run time depends on how
// soon the limits are met.
`timescale 1ns / 1ps

module trapezoid_velocity_planner #(
  parameter int MAX_ITERATIONS = tvp_pkg::DEF_MAX_ITERATIONS,
  parameter int FRAC_BITS      = tvp_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tvp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               in_angle_change,
  input  logic [30:0]                      in_planned_time,
  input  logic signed [31:0]               in_start_speed,
  input  logic signed [31:0]               in_end_speed,
  output logic                             out_valid,
  output logic [30:0]                      out_total_time,
  output logic signed [31:0]               out_cruise_speed,
  output logic [30:0]                      out_accel_time,
  output logic [30:0]                      out_cruise_time,
  output logic [30:0]                      out_decel_time,
  output logic signed [31:0]               out_accel_rate,
  output logic signed [31:0]               out_decel_rate,
  output logic                             out_iteration_overflow
);

  localparam int NW = $clog2(MAX_ITERATIONS + 1);
  localparam int DVD_W = tvp_pkg::DVD_W;
  localparam int DVS_W = tvp_pkg::DVS_W;
  localparam int MOP_W = tvp_pkg::MOP_W;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  // Configuration registers.
  logic [30:0] max_accel_r, max_speed_r, time_step_r, init_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r  <= tvp_pkg::RST_MAX_ACCEL;
      max_speed_r  <= tvp_pkg::RST_MAX_SPEED;
      time_step_r  <= tvp_pkg::RST_TIME_STEP;
      init_ratio_r <= tvp_pkg::RST_INITIAL_RATIO;
    end else if (cfg_we) begin
      case (cfg_index)
        tvp_pkg::REG_MAX_ACCEL:     max_accel_r  <= cfg_data;
        tvp_pkg::REG_MAX_SPEED:     max_speed_r  <= cfg_data;
        tvp_pkg::REG_TIME_STEP:     time_step_r  <= cfg_data;
        tvp_pkg::REG_INITIAL_RATIO: init_ratio_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tvp_pkg::state_t state_r, state_nxt;

  logic signed [31:0] sita_r, sita_nxt, ws_r, ws_nxt, wg_r, wg_nxt;
  logic [30:0] tplan_r, tplan_nxt;
  logic [30:0] k_r, k_nxt;
  logic        pass_r, pass_nxt;
  logic        ran_r, ran_nxt;
  logic        capped_r, capped_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [30:0] t_r, t_nxt;
  logic [31:0] t2_r, t2_nxt;
  logic [30:0] t1_r, t1_nxt, t3_r, t3_nxt;
  logic [31:0] w_r, w_nxt, a_acc_r, a_acc_nxt, a_dec_r, a_dec_nxt;
  logic        sp_ok_r, sp_ok_nxt, ok1_r, ok1_nxt, ok3_r, ok3_nxt;
  logic signed [65:0] num_r, num_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Shared multiplier, registered.
  logic signed [MOP_W-1:0]   mul_a, mul_b;
  logic signed [2*MOP_W-1:0] prod_r;

  // Shared restoring divider.
  logic [DVD_W-1:0] div_q_r, div_q_nxt;
  logic [DVS_W:0]   div_rem_r, div_rem_nxt;
  logic [DVS_W-1:0] div_dvs_r, div_dvs_nxt;
  logic [5:0]       div_cnt_r, div_cnt_nxt;
  logic             div_run_r, div_run_nxt;
  logic             div_neg_r, div_neg_nxt;
  logic             div_ld, div_ld_neg;
  logic [DVD_W-1:0] div_ld_dvd;
  logic [DVS_W-1:0] div_ld_dvs;
  logic [DVS_W:0]   div_shift;

  logic [31:0]        kp;
  logic [30:0]        span;
  logic [31:0]        t_sum;
  logic signed [32:0] diff1, diff3, nu_s, de_s;
  logic [32:0]        diff1_mag, diff3_mag, nu, de;
  logic signed [65:0] num_fin;
  logic [31:0]        t_step;

  always_comb begin
    kp        = {1'b0, k_r} + ONE;
    span      = 31'({1'b0, t_r} - t2_r);
    t_sum     = {1'b0, t_r} + t2_r;
    diff1     = {w_r[31], w_r} - {ws_r[31], ws_r};
    diff3     = {wg_r[31], wg_r} - {w_r[31], w_r};
    diff1_mag = diff1[32] ? 33'(-diff1) : 33'(diff1);
    diff3_mag = diff3[32] ? 33'(-diff3) : 33'(diff3);
    nu_s      = diff3;
    de_s      = diff1;
    nu        = nu_s[32] ? 33'(-nu_s) : 33'(nu_s);
    de        = de_s[32] ? 33'(-de_s) : 33'(de_s);
    num_fin   = num_r - 66'(prod_r);
    t_step    = {1'b0, t_r} + {1'b0, time_step_r};
  end

  always_comb begin
    case (state_r)
      tvp_pkg::S_T1: begin
        mul_a = MOP_W'(span);
        mul_b = MOP_W'(k_r);
      end
      tvp_pkg::S_T3: begin
        mul_a = MOP_W'(t1_r);
        mul_b = MOP_W'(ws_r);
      end
      tvp_pkg::S_M1: begin
        mul_a = MOP_W'(t3_r);
        mul_b = MOP_W'(wg_r);
      end
      tvp_pkg::S_KM: begin
        mul_a = MOP_W'(k_r);
        mul_b = $signed({1'b0, nu});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    sita_nxt      = sita_r;
    ws_nxt        = ws_r;
    wg_nxt        = wg_r;
    tplan_nxt     = tplan_r;
    k_nxt         = k_r;
    pass_nxt      = pass_r;
    ran_nxt       = ran_r;
    capped_nxt    = capped_r;
    n_nxt         = n_r;
    t_nxt         = t_r;
    t2_nxt        = t2_r;
    t1_nxt        = t1_r;
    t3_nxt        = t3_r;
    w_nxt         = w_r;
    a_acc_nxt     = a_acc_r;
    a_dec_nxt     = a_dec_r;
    sp_ok_nxt     = sp_ok_r;
    ok1_nxt       = ok1_r;
    ok3_nxt       = ok3_r;
    num_nxt       = num_r;
    out_valid_nxt = 1'b0;
    div_ld        = 1'b0;
    div_ld_dvd    = '0;
    div_ld_dvs    = '0;
    div_ld_neg    = 1'b0;

    case (state_r)
      tvp_pkg::S_IDLE: begin
        if (start) begin
          sita_nxt   = in_angle_change;
          tplan_nxt  = in_planned_time;
          ws_nxt     = in_start_speed;
          wg_nxt     = in_end_speed;
          k_nxt      = init_ratio_r;
          pass_nxt   = 1'b0;
          capped_nxt = 1'b0;
          state_nxt  = tvp_pkg::S_PASS;
        end
      end
      tvp_pkg::S_PASS: begin
        t_nxt     = tplan_r;
        t2_nxt    = '0;
        n_nxt     = '0;
        ran_nxt   = 1'b0;
        t1_nxt    = '0;
        t3_nxt    = '0;
        w_nxt     = '0;
        a_acc_nxt = '0;
        a_dec_nxt = '0;
        state_nxt = tvp_pkg::S_CHECK;
      end
      tvp_pkg::S_CHECK: begin
        if (t2_r >= {1'b0, t_r}) begin
          state_nxt = tvp_pkg::S_END;
        end else if (n_r >= NW'(MAX_ITERATIONS)) begin
          capped_nxt = 1'b1;
          state_nxt  = tvp_pkg::S_END;
        end else begin
          n_nxt      = n_r + NW'(1);
          ran_nxt    = 1'b1;
          div_ld     = 1'b1;
          div_ld_dvd = DVD_W'(span) << FRAC_BITS;
          div_ld_dvs = DVS_W'(kp);
          state_nxt  = tvp_pkg::S_T1;
        end
      end
      tvp_pkg::S_T1: begin
        // The span times ratio product is ready in prod_r by the end.
        if (!div_run_r) begin
          t1_nxt     = div_q_r[30:0];
          div_ld     = 1'b1;
          div_ld_dvd = prod_r[DVD_W-1:0];
          div_ld_dvs = DVS_W'(kp);
          state_nxt  = tvp_pkg::S_T3;
        end
      end
      tvp_pkg::S_T3: begin
        if (!div_run_r) begin
          t3_nxt    = div_q_r[30:0];
          state_nxt = tvp_pkg::S_M1;
        end
      end
      tvp_pkg::S_M1: begin
        num_nxt   = ($signed({{34{sita_r[31]}}, sita_r}) <<< (FRAC_BITS + 1))
                    - 66'(prod_r);
        state_nxt = tvp_pkg::S_M2;
      end
      tvp_pkg::S_M2: begin
        div_ld     = 1'b1;
        div_ld_neg = num_fin[65];
        div_ld_dvd = num_fin[65] ? DVD_W'(-num_fin) : DVD_W'(num_fin);
        div_ld_dvs = DVS_W'(t_sum);
        state_nxt  = tvp_pkg::S_WD;
      end
      tvp_pkg::S_WD: begin
        if (!div_run_r) begin
          w_nxt     = tvp_pkg::sat_sm(div_neg_r, div_q_r);
          sp_ok_nxt = div_q_r <= DVD_W'(max_speed_r);
          state_nxt = tvp_pkg::S_A1L;
        end
      end
      tvp_pkg::S_A1L: begin
        if (t1_r == '0) begin
          a_acc_nxt = tvp_pkg::zero_time_rate(diff1);
          ok1_nxt   = 1'b0;
          state_nxt = tvp_pkg::S_A3L;
        end else begin
          div_ld     = 1'b1;
          div_ld_neg = diff1[32];
          div_ld_dvd = DVD_W'(diff1_mag) << FRAC_BITS;
          div_ld_dvs = DVS_W'(t1_r);
          state_nxt  = tvp_pkg::S_A1;
        end
      end
      tvp_pkg::S_A1: begin
        if (!div_run_r) begin
          a_acc_nxt = tvp_pkg::sat_sm(div_neg_r, div_q_r);
          ok1_nxt   = div_q_r <= DVD_W'(max_accel_r);
          state_nxt = tvp_pkg::S_A3L;
        end
      end
      tvp_pkg::S_A3L: begin
        if (t3_r == '0) begin
          a_dec_nxt = tvp_pkg::zero_time_rate(diff3);
          ok3_nxt   = 1'b0;
          state_nxt = tvp_pkg::S_UPD;
        end else begin
          div_ld     = 1'b1;
          div_ld_neg = diff3[32];
          div_ld_dvd = DVD_W'(diff3_mag) << FRAC_BITS;
          div_ld_dvs = DVS_W'(t3_r);
          state_nxt  = tvp_pkg::S_A3;
        end
      end
      tvp_pkg::S_A3: begin
        if (!div_run_r) begin
          a_dec_nxt = tvp_pkg::sat_sm(div_neg_r, div_q_r);
          ok3_nxt   = div_q_r <= DVD_W'(max_accel_r);
          state_nxt = tvp_pkg::S_UPD;
        end
      end
      tvp_pkg::S_UPD: begin
        if (sp_ok_r && ok1_r && ok3_r) begin
          state_nxt = tvp_pkg::S_END;
        end else if (ok1_r && ok3_r) begin
          t2_nxt    = t2_r + {1'b0, time_step_r};
          state_nxt = tvp_pkg::S_CHECK;
        end else begin
          t_nxt     = t_step[31] ? tvp_pkg::MAX31 : t_step[30:0];
          state_nxt = tvp_pkg::S_CHECK;
        end
      end
      tvp_pkg::S_END: begin
        if (pass_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = tvp_pkg::S_DONE;
        end else begin
          pass_nxt = 1'b1;
          if (ran_r && (w_r != ws_r) && (w_r != wg_r)) begin
            state_nxt = tvp_pkg::S_KM;
          end else begin
            state_nxt = tvp_pkg::S_PASS;
          end
        end
      end
      tvp_pkg::S_KM: begin
        state_nxt = tvp_pkg::S_KL;
      end
      tvp_pkg::S_KL: begin
        div_ld     = 1'b1;
        div_ld_dvd = prod_r[DVD_W-1:0];
        div_ld_dvs = de;
        state_nxt  = tvp_pkg::S_KD;
      end
      tvp_pkg::S_KD: begin
        if (!div_run_r) begin
          k_nxt     = (div_q_r > DVD_W'(tvp_pkg::MAX31)) ? tvp_pkg::MAX31 : div_q_r[30:0];
          state_nxt = tvp_pkg::S_PASS;
        end
      end
      tvp_pkg::S_DONE: begin
        state_nxt = tvp_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tvp_pkg::S_IDLE;
      end
    endcase
  end

  // One quotient bit per cycle.
  always_comb begin
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_dvs_nxt = div_dvs_r;
    div_cnt_nxt = div_cnt_r;
    div_run_nxt = div_run_r;
    div_neg_nxt = div_neg_r;
    div_shift   = {div_rem_r[DVS_W-1:0], div_q_r[DVD_W-1]};
    if (div_ld) begin
      div_q_nxt   = div_ld_dvd;
      div_rem_nxt = '0;
      div_dvs_nxt = div_ld_dvs;
      div_cnt_nxt = 6'(DVD_W - 1);
      div_run_nxt = 1'b1;
      div_neg_nxt = div_ld_neg;
    end else if (div_run_r) begin
      if (div_shift >= {1'b0, div_dvs_r}) begin
        div_rem_nxt = div_shift - {1'b0, div_dvs_r};
        div_q_nxt   = {div_q_r[DVD_W-2:0], 1'b1};
      end else begin
        div_rem_nxt = div_shift;
        div_q_nxt   = {div_q_r[DVD_W-2:0], 1'b0};
      end
      div_cnt_nxt = div_cnt_r - 6'd1;
      if (div_cnt_r == 6'd0) begin
        div_run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tvp_pkg::S_IDLE;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      div_run_r   <= div_run_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sita_r    <= sita_nxt;
    ws_r      <= ws_nxt;
    wg_r      <= wg_nxt;
    tplan_r   <= tplan_nxt;
    k_r       <= k_nxt;
    pass_r    <= pass_nxt;
    ran_r     <= ran_nxt;
    capped_r  <= capped_nxt;
    t_r       <= t_nxt;
    t2_r      <= t2_nxt;
    t1_r      <= t1_nxt;
    t3_r      <= t3_nxt;
    w_r       <= w_nxt;
    a_acc_r   <= a_acc_nxt;
    a_dec_r   <= a_dec_nxt;
    sp_ok_r   <= sp_ok_nxt;
    ok1_r     <= ok1_nxt;
    ok3_r     <= ok3_nxt;
    num_r     <= num_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_dvs_r <= div_dvs_nxt;
    div_cnt_r <= div_cnt_nxt;
    div_neg_r <= div_neg_nxt;
  end

  assign busy                   = (state_r != tvp_pkg::S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_total_time         = t_r;
  assign out_cruise_speed       = w_r;
  assign out_accel_time         = t1_r;
  assign out_cruise_time        = t2_r[30:0];
  assign out_decel_time         = t3_r;
  assign out_accel_rate         = a_acc_r;
  assign out_decel_rate         = a_dec_r;
  assign out_iteration_overflow = capped_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_beat_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == tvp_pkg::S_DONE))
    else $error("result beat outside the done state");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_run_r |-> (state_r == tvp_pkg::S_T1 || state_r == tvp_pkg::S_T3 ||
                   state_r == tvp_pkg::S_WD || state_r == tvp_pkg::S_A1 ||
                   state_r == tvp_pkg::S_A3 || state_r == tvp_pkg::S_KD))
    else $error("divider running in a state that does not wait for it");

  a_iter_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_ITERATIONS))
    else $error("step counter passed the iteration cap");

endmodule

FILE: bench/tb_trapezoid_velocity_planner.sv
// ----------------------------------------------------------------------------
// Trapezoid velocity planner testbench
// Drives move requests through the command port, predicts each plan with a
// cycle-free model of the two search passes and checks every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trapezoid_velocity_planner;

  localparam int  ITER_CAP  = tvp_pkg::DEF_MAX_ITERATIONS;
  localparam int  QBITS     = tvp_pkg::DEF_FRAC_BITS;
  localparam longint ONE    = 64'sd1 <<< QBITS;
  localparam int  STALL_MAX = 5_000_000;

  typedef struct {
    logic signed [31:0] angle;
    logic [30:0]        tplan;
    logic signed [31:0] v_start;
    logic signed [31:0] v_end;
  } move_t;

  typedef struct {
    logic [30:0]        total_time;
    logic signed [31:0] cruise_speed;
    logic [30:0]        accel_time;
    logic [30:0]        cruise_time;
    logic [30:0]        decel_time;
    logic signed [31:0] accel_rate;
    logic signed [31:0] decel_rate;
    logic               overflow;
  } plan_t;

  typedef struct {
    plan_t plan;
    bit    ran;
    bit    capped;
  } pass_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index = tvp_pkg::REG_MAX_ACCEL;
  logic [tvp_pkg::CFG_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_angle_change = '0;
  logic [30:0] in_planned_time = '0;
  logic signed [31:0] in_start_speed = '0;
  logic signed [31:0] in_end_speed = '0;
  logic out_valid;
  logic [30:0] out_total_time, out_accel_time, out_cruise_time, out_decel_time;
  logic signed [31:0] out_cruise_speed, out_accel_rate, out_decel_rate;
  logic out_iteration_overflow;

  // Register copies used by the planner model.
  bit [63:0] lim_accel = 64'(tvp_pkg::RST_MAX_ACCEL);
  bit [63:0] lim_speed = 64'(tvp_pkg::RST_MAX_SPEED);
  bit [63:0] step_size = 64'(tvp_pkg::RST_TIME_STEP);
  bit [63:0] ratio0    = 64'(tvp_pkg::RST_INITIAL_RATIO);

  move_t pending_moves[$];
  plan_t expected_plans[$];
  int errors = 0;
  int stall_cycles = 0;
  int beats_in = 0;
  bit calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  trapezoid_velocity_planner u_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
    .in_angle_change, .in_planned_time, .in_start_speed, .in_end_speed,
    .out_valid, .out_total_time, .out_cruise_speed, .out_accel_time,
    .out_cruise_time, .out_decel_time, .out_accel_rate, .out_decel_rate,
    .out_iteration_overflow
  );

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit [63:0] absval(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Acceleration over one segment; returns 1 when the segment time is nonzero and the rate is within the limit.
  function automatic bit rate_ok(longint diff, bit [63:0] seg, output longint rate);
    longint r;
    if (seg == 0) begin
      rate = (diff > 0) ? 64'sd2147483647 : ((diff < 0) ? -64'sd2147483648 : 0);
      return 1'b0;
    end
    r = (diff * ONE) / longint'(seg);
    rate = sat32(r);
    return absval(r) <= lim_accel;
  endfunction

  function automatic pass_t search_pass(move_t m, bit [63:0] k);
    pass_t p;
    bit [63:0] t, t2, kp, span, t1, t3;
    longint num, wraw, w, a1, a3, ws, wg;
    bit sp_ok, ok1, ok3;
    int n;
    t = 64'(m.tplan);
    t2 = 0;
    kp = k + 64'(ONE);
    n = 0;
    ws = m.v_start;
    wg = m.v_end;
    w = 0; a1 = 0; a3 = 0; t1 = 0; t3 = 0;
    p.ran = 1'b0;
    p.capped = 1'b0;
    while (t2 < t) begin
      if (n >= ITER_CAP) begin
        p.capped = 1'b1;
        break;
      end
      n++;
      p.ran = 1'b1;
      span = t - t2;
      t1 = (span << QBITS) / kp;
      t3 = (span * k) / kp;
      num = longint'(m.angle) * 2 * ONE - longint'(t1) * ws - longint'(t3) * wg;
      wraw = num / longint'(t + t2);
      w = sat32(wraw);
      sp_ok = absval(wraw) <= lim_speed;
      ok1 = rate_ok(w - ws, t1, a1);
      ok3 = rate_ok(wg - w, t3, a3);
      if (sp_ok && ok1 && ok3) break;
      if (!sp_ok && ok1 && ok3) begin
        t2 += step_size;
      end else begin
        t += step_size;
        if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
      end
    end
    p.plan.total_time   = t[30:0];
    p.plan.cruise_speed = w[31:0];
    p.plan.accel_time   = t1[30:0];
    p.plan.cruise_time  = t2[30:0];
    p.plan.decel_time   = t3[30:0];
    p.plan.accel_rate   = a1[31:0];
    p.plan.decel_rate   = a3[31:0];
    p.plan.overflow     = 1'b0;
    return p;
  endfunction

  function automatic plan_t plan_move(move_t m);
    pass_t first, second;
    bit [63:0] k, q;
    longint w;
    k = ratio0;
    first = search_pass(m, k);
    w = first.plan.cruise_speed;
    if (first.ran && w != m.v_start && w != m.v_end) begin
      q = (k * absval(longint'(m.v_end) - w)) / absval(w - longint'(m.v_start));
      k = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
    end
    second = search_pass(m, k);
    second.plan.overflow = first.capped | second.capped;
    return second.plan;
  endfunction

  // Driver: one nonblocking assignment per signal per edge.
  always @(posedge clk) begin
    bit taken;
    bit go;
    taken = 1'b0;
    if (rst_n && start && !busy) begin
      expected_plans.push_back(plan_move(pending_moves.pop_front()));
      beats_in++;
      taken = 1'b1;
    end
    go = calm || ($urandom_range(99) >= 8);
    if (rst_n && pending_moves.size() > 0 && go && (taken || !start || busy)) begin
      start           <= 1'b1;
      in_angle_change <= pending_moves[0].angle;
      in_planned_time <= pending_moves[0].tplan;
      in_start_speed  <= pending_moves[0].v_start;
      in_end_speed    <= pending_moves[0].v_end;
    end else if (taken || !go || pending_moves.size() == 0) begin
      start <= 1'b0;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    plan_t e;
    if (out_valid) begin
      if (expected_plans.size() == 0) begin
        $error("result beat with no plan outstanding");
        errors++;
      end else begin
        e = expected_plans.pop_front();
        if (out_total_time !== e.total_time) begin
          $error("total_time exp %0d got %0d", e.total_time, out_total_time);
          errors++;
        end
        if (out_cruise_speed !== e.cruise_speed) begin
          $error("cruise_speed exp %0d got %0d", e.cruise_speed, out_cruise_speed);
          errors++;
        end
        if (out_accel_time !== e.accel_time) begin
          $error("accel_time exp %0d got %0d", e.accel_time, out_accel_time);
          errors++;
        end
        if (out_cruise_time !== e.cruise_time) begin
          $error("cruise_time exp %0d got %0d", e.cruise_time, out_cruise_time);
          errors++;
        end
        if (out_decel_time !== e.decel_time) begin
          $error("decel_time exp %0d got %0d", e.decel_time, out_decel_time);
          errors++;
        end
        if (out_accel_rate !== e.accel_rate) begin
          $error("accel_rate exp %0d got %0d", e.accel_rate, out_accel_rate);
          errors++;
        end
        if (out_decel_rate !== e.decel_rate) begin
          $error("decel_rate exp %0d got %0d", e.decel_rate, out_decel_rate);
          errors++;
        end
        if (out_iteration_overflow !== e.overflow) begin
          $error("iteration_overflow exp %0d got %0d", e.overflow,
                 out_iteration_overflow);
          errors++;
        end
      end
    end
    if (out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [tvp_pkg::CFG_IDX_W-1:0] idx,
                           logic [tvp_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      tvp_pkg::REG_MAX_ACCEL:     lim_accel = 64'(val);
      tvp_pkg::REG_MAX_SPEED:     lim_speed = 64'(val);
      tvp_pkg::REG_TIME_STEP:     step_size = 64'(val);
      tvp_pkg::REG_INITIAL_RATIO: ratio0    = 64'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_moves.size() > 0 || expected_plans.size() > 0 || busy || start);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_move(logic [31:0] a, logic [30:0] tp, logic [31:0] vs,
                          logic [31:0] ve);
    move_t m;
    m.angle = a;
    m.tplan = tp;
    m.v_start = vs;
    m.v_end = ve;
    pending_moves.push_back(m);
  endtask

  // Mostly modest moves, with a share of full-range noise.
  task automatic add_random_move();
    if ($urandom_range(9) == 0) begin
      add_move($urandom, 31'($urandom), $urandom, $urandom);
    end else begin
      add_move(32'($signed($urandom_range(2_097_152)) - 1_048_576),
               31'($urandom_range(524_288, 1)),
               32'($signed($urandom_range(524_288)) - 262_144),
               32'($signed($urandom_range(524_288)) - 262_144));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero planned time, a standstill and a just-fitting move each way.
    add_move(32'sd65536, 31'd0, 32'sd0, 32'sd0);
    add_move(32'sd0, 31'd65536, 32'sd0, 32'sd0);
    add_move(32'sd65536, 31'd131072, 32'sd0, 32'sd0);
    add_move(-32'sd65536, 31'd131072, 32'sd0, 32'sd0);
    drain();

    // Loose limits and a coarse step for the field extremes.
    write_reg(tvp_pkg::REG_MAX_ACCEL, tvp_pkg::MAX31);
    write_reg(tvp_pkg::REG_MAX_SPEED, tvp_pkg::MAX31);
    write_reg(tvp_pkg::REG_TIME_STEP, 31'd16_777_216);
    add_move(32'h7FFF_FFFF, tvp_pkg::MAX31, 32'h7FFF_FFFF, 32'h8000_0000);
    add_move(32'h8000_0000, tvp_pkg::MAX31, 32'h8000_0000, 32'h7FFF_FFFF);
    add_move(32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_move(32'h7FFF_FFFF, 31'd1, 32'sd0, 32'sd0);
    add_move(32'sd0, 31'd65536, 32'sd65536, 32'sd65536);
    add_move(32'sd131072, 31'd65536, 32'sd65536, 32'sd0);
    drain();
    write_reg(tvp_pkg::REG_INITIAL_RATIO, tvp_pkg::MAX31);
    add_move(32'sd131072, 31'd65536, 32'sd0, 32'sd65536);
    add_move(32'h7FFF_FFFF, tvp_pkg::MAX31, 32'sd0, 32'sd0);
    drain();
    write_reg(tvp_pkg::REG_INITIAL_RATIO, 31'd1);
    add_move(32'sd131072, 31'd65536, 32'sd0, 32'sd65536);
    add_move(32'h8000_0000, tvp_pkg::MAX31, 32'h7FFF_FFFF, 32'sd0);
    drain();

    // A zero step with zero limits never converges and runs into the cap.
    write_reg(tvp_pkg::REG_TIME_STEP, 31'd0);
    write_reg(tvp_pkg::REG_MAX_ACCEL, 31'd0);
    write_reg(tvp_pkg::REG_MAX_SPEED, 31'd0);
    add_move(32'sd65536, 31'd1, 32'sd0, 32'sd0);
    drain();

    // Random phases, each under freshly drawn settings, but the first keeps both limits at the maximum.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(tvp_pkg::REG_MAX_ACCEL, (ph == 0) ? tvp_pkg::MAX31 :
                31'($urandom_range(tvp_pkg::MAX31, 1 << 24)));
      write_reg(tvp_pkg::REG_MAX_SPEED, (ph == 0) ? tvp_pkg::MAX31 :
                31'($urandom_range(tvp_pkg::MAX31, 1 << 24)));
      write_reg(tvp_pkg::REG_TIME_STEP, 31'($urandom_range(1 << 26, 1 << 22)));
      write_reg(tvp_pkg::REG_INITIAL_RATIO, 31'($urandom_range(262_144, 16_384)));
      calm = (ph == 2);
      for (int i = 0; i < 500; i++) add_random_move();
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tvp_pkg.sv
rtl/core/trapezoid_velocity_planner.sv
bench/tb_trapezoid_velocity_planner.sv
